// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true at a rising edge outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- design/pfop_pkg.sv -----
// ----------------------------------------------------------------------------
// pfop_pkg
// Shared types and constants of the pack format option parser
// ----------------------------------------------------------------------------
package pfop_pkg;

    localparam int MAX_INT_BYTES = 16;
    localparam int COUNT_W       = 32;
    localparam int SIZE_W        = 32;
    localparam int OFF_W         = 32;
    localparam int CHAR_W        = 8;
    localparam int PAD_W         = 4;
    localparam int ALIGN_W       = 5;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 3;

    // largest numeral that may still take another digit
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] NUM_LIMIT =
        (COUNT_MAX - COUNT_W'(9)) / COUNT_W'(10);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_LITTLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_MAX_ALIGN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_BYTES        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_BYTES       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_BYTES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZET_BYTES      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BYTES     = 3'd6;

    typedef enum logic [3:0] {
        K_INT      = 4'd0,
        K_UINT     = 4'd1,
        K_FLOAT    = 4'd2,
        K_NUMBER   = 4'd3,
        K_DOUBLE   = 4'd4,
        K_CHAR     = 4'd5,
        K_STRING   = 4'd6,
        K_ZSTR     = 4'd7,
        K_PADDING  = 4'd8,
        K_PADALIGN = 4'd9,
        K_NOP      = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE     = 3'd0,
        E_BAD_OPT  = 3'd1,
        E_INT_SIZE = 3'd2,
        E_C_SIZE   = 3'd3,
        E_X_TARGET = 3'd4,
        E_ALIGN    = 3'd5
    } err_t;

    typedef struct packed {
        logic             native_little;
        logic [CFG_W-1:0] native_max_align;
        logic [CFG_W-1:0] int_bytes;
        logic [CFG_W-1:0] long_bytes;
        logic [CFG_W-1:0] integer_bytes;
        logic [CFG_W-1:0] sizet_bytes;
        logic [CFG_W-1:0] number_bytes;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [SIZE_W-1:0] size;
        logic [PAD_W-1:0]  pad;
        logic              little;
        err_t              error;
        logic              run_end;
        logic              done_res;
    } res_t;

endpackage

// ----- design/pfop_ifs.sv -----
// ----------------------------------------------------------------------------
// pfop_ifs
// Valid/ready channels for format characters and parsed options
// ----------------------------------------------------------------------------
interface pfop_fmt_if;
    logic                         valid;
    logic                         ready;
    logic [pfop_pkg::CHAR_W-1:0]  fmt_char;
    logic [pfop_pkg::OFF_W-1:0]   offset;
    logic                         format_end;

    modport source (output valid, fmt_char, offset, format_end, input ready);
    modport sink   (input valid, fmt_char, offset, format_end, output ready);
endinterface

interface pfop_res_if;
    logic                         valid;
    logic                         ready;
    pfop_pkg::kind_t              kind;
    logic [pfop_pkg::SIZE_W-1:0]  size;
    logic [pfop_pkg::PAD_W-1:0]   pad;
    logic                         little;
    pfop_pkg::err_t               error;
    logic                         run_end;
    logic                         done_res;

    modport source (output valid, kind, size, pad, little, error, run_end, done_res,
                    input ready);
    modport sink   (input valid, kind, size, pad, little, error, run_end, done_res,
                    output ready);
endinterface

// ----- design/pfop_parser.sv -----
// ----------------------------------------------------------------------------
// pfop_parser
// Per-character option decode with parser state; yields up to two results
// ----------------------------------------------------------------------------
module pfop_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [pfop_pkg::CHAR_W-1:0]  fmt_char,
    input  logic [pfop_pkg::OFF_W-1:0]   offset,
    input  logic                         format_end,
    input  pfop_pkg::cfg_t               cfg,
    output pfop_pkg::res_t               res0,
    output pfop_pkg::res_t               res1,
    output logic [1:0]                   res_num
);

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UP_B    = 8'h42;
    localparam logic [7:0] CH_UP_H    = 8'h48;
    localparam logic [7:0] CH_UP_I    = 8'h49;
    localparam logic [7:0] CH_UP_J    = 8'h4A;
    localparam logic [7:0] CH_UP_L    = 8'h4C;
    localparam logic [7:0] CH_UP_T    = 8'h54;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LO_B    = 8'h62;
    localparam logic [7:0] CH_LO_C    = 8'h63;
    localparam logic [7:0] CH_LO_D    = 8'h64;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_LO_H    = 8'h68;
    localparam logic [7:0] CH_LO_I    = 8'h69;
    localparam logic [7:0] CH_LO_J    = 8'h6A;
    localparam logic [7:0] CH_LO_L    = 8'h6C;
    localparam logic [7:0] CH_LO_N    = 8'h6E;
    localparam logic [7:0] CH_LO_S    = 8'h73;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    localparam int CW = pfop_pkg::COUNT_W;
    localparam int SW = pfop_pkg::SIZE_W;
    localparam int AW = pfop_pkg::ALIGN_W;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_NUM   = 2'd1,
        PH_XWAIT = 2'd2,
        PH_SKIP  = 2'd3
    } phase_t;

    typedef struct packed {
        pfop_pkg::kind_t          kind;
        logic [SW-1:0]            size;
        logic [pfop_pkg::PAD_W-1:0] pad;
        pfop_pkg::err_t           err;
        logic                     skip;
    } fin_t;

    typedef struct packed {
        pfop_pkg::kind_t kind;
        logic [SW-1:0]   size;
        pfop_pkg::err_t  err;
        logic            set_ma;
        logic [AW-1:0]   ma;
    } rsv_t;

    typedef struct packed {
        pfop_pkg::kind_t kind;
        logic [SW-1:0]   size;
        pfop_pkg::err_t  err;
        logic            little;
    } dec_t;

    function automatic logic bad_int_size(input logic [CW-1:0] sz);
        return (sz == '0) || (sz > CW'(pfop_pkg::MAX_INT_BYTES));
    endfunction

    function automatic logic takes_numeral(input logic [7:0] c);
        return (c == CH_LO_I) || (c == CH_UP_I) || (c == CH_LO_S) ||
               (c == CH_LO_C) || (c == CH_BANG);
    endfunction

    // padding, X target check and clamp to the current maximum alignment
    function automatic fin_t finish_opt(input pfop_pkg::kind_t kind,
                                        input logic [SW-1:0] size,
                                        input pfop_pkg::err_t err_in,
                                        input logic is_x,
                                        input logic [AW-1:0] malign,
                                        input logic [pfop_pkg::OFF_W-1:0] loff);
        fin_t           f;
        logic [AW-1:0]  align;
        pfop_pkg::err_t err;
        err   = err_in;
        align = '0;
        f     = '0;
        if (err == pfop_pkg::E_NONE && is_x && (kind == pfop_pkg::K_CHAR || size == '0))
            err = pfop_pkg::E_X_TARGET;
        if (err == pfop_pkg::E_NONE && size > SW'(1) && (is_x || kind != pfop_pkg::K_CHAR))
        begin
            align = (size > SW'(malign)) ? malign : size[AW-1:0];
            if (align == '0 || (align & (align - AW'(1))) != '0)
                err = pfop_pkg::E_ALIGN;
            else
                f.pad = pfop_pkg::PAD_W'((align - (loff[AW-1:0] & (align - AW'(1))))
                                         & (align - AW'(1)));
        end
        f.err  = err;
        f.skip = (err != pfop_pkg::E_NONE);
        if (err != pfop_pkg::E_NONE)
        begin
            f.kind = pfop_pkg::K_NOP;
            f.size = '0;
            f.pad  = '0;
        end
        else if (is_x)
        begin
            f.kind = pfop_pkg::K_PADALIGN;
            f.size = '0;
        end
        else
        begin
            f.kind = kind;
            f.size = size;
        end
        return f;
    endfunction

    // closes an option that was waiting for its numeral
    function automatic rsv_t resolve_opt(input logic [7:0] pend,
                                         input logic [CW-1:0] num,
                                         input logic seen,
                                         input pfop_pkg::cfg_t c);
        rsv_t          v;
        logic [CW-1:0] sz;
        v      = '0;
        v.kind = pfop_pkg::K_NOP;
        v.err  = pfop_pkg::E_NONE;
        sz     = '0;
        unique case (pend)
            CH_LO_I, CH_UP_I:
            begin
                sz = seen ? num : CW'(c.int_bytes);
                if (bad_int_size(sz))
                    v.err = pfop_pkg::E_INT_SIZE;
                else
                    v.size = SW'(sz);
                v.kind = (pend == CH_LO_I) ? pfop_pkg::K_INT : pfop_pkg::K_UINT;
            end
            CH_LO_S:
            begin
                sz = seen ? num : CW'(c.sizet_bytes);
                if (bad_int_size(sz))
                    v.err = pfop_pkg::E_INT_SIZE;
                else
                    v.size = SW'(sz);
                v.kind = pfop_pkg::K_STRING;
            end
            CH_LO_C:
            begin
                if (!seen)
                    v.err = pfop_pkg::E_C_SIZE;
                else
                    v.size = SW'(num);
                v.kind = pfop_pkg::K_CHAR;
            end
            default:
            begin
                sz = seen ? num : CW'(c.native_max_align);
                if (bad_int_size(sz))
                    v.err = pfop_pkg::E_INT_SIZE;
                else
                begin
                    v.set_ma = 1'b1;
                    v.ma     = sz[AW-1:0];
                end
            end
        endcase
        return v;
    endfunction

    function automatic dec_t decode_plain(input logic [7:0] ch,
                                          input logic little_in,
                                          input pfop_pkg::cfg_t c);
        dec_t d;
        d        = '0;
        d.kind   = pfop_pkg::K_NOP;
        d.err    = pfop_pkg::E_NONE;
        d.little = little_in;
        unique case (ch)
            CH_LO_B:  begin d.size = SW'(1); d.kind = pfop_pkg::K_INT;  end
            CH_UP_B:  begin d.size = SW'(1); d.kind = pfop_pkg::K_UINT; end
            CH_LO_H:  begin d.size = SW'(2); d.kind = pfop_pkg::K_INT;  end
            CH_UP_H:  begin d.size = SW'(2); d.kind = pfop_pkg::K_UINT; end
            CH_LO_L:  begin d.size = SW'(c.long_bytes); d.kind = pfop_pkg::K_INT;  end
            CH_UP_L:  begin d.size = SW'(c.long_bytes); d.kind = pfop_pkg::K_UINT; end
            CH_LO_J:  begin d.size = SW'(c.integer_bytes); d.kind = pfop_pkg::K_INT;  end
            CH_UP_J:  begin d.size = SW'(c.integer_bytes); d.kind = pfop_pkg::K_UINT; end
            CH_UP_T:  begin d.size = SW'(c.sizet_bytes); d.kind = pfop_pkg::K_UINT; end
            CH_LO_F:  begin d.size = SW'(4); d.kind = pfop_pkg::K_FLOAT; end
            CH_LO_N:  begin d.size = SW'(c.number_bytes); d.kind = pfop_pkg::K_NUMBER; end
            CH_LO_D:  begin d.size = SW'(8); d.kind = pfop_pkg::K_DOUBLE; end
            CH_LO_Z:  d.kind = pfop_pkg::K_ZSTR;
            CH_LO_X:  begin d.size = SW'(1); d.kind = pfop_pkg::K_PADDING; end
            CH_UP_X:  d.kind = pfop_pkg::K_PADALIGN;
            CH_SPACE: ;
            CH_LT:    d.little = 1'b1;
            CH_GT:    d.little = 1'b0;
            CH_EQ:    d.little = c.native_little;
            default:  d.err = pfop_pkg::E_BAD_OPT;
        endcase
        return d;
    endfunction

    function automatic pfop_pkg::res_t to_res(input fin_t f, input logic little);
        pfop_pkg::res_t r;
        r.kind     = f.kind;
        r.size     = f.size;
        r.pad      = f.pad;
        r.little   = little;
        r.error    = f.err;
        r.run_end  = 1'b0;
        r.done_res = 1'b0;
        return r;
    endfunction

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  pend_reg, pend_next;
    logic [CW-1:0]               num_reg, num_next;
    logic                        seen_reg, seen_next;
    logic                        apend_reg, apend_next;
    logic [pfop_pkg::OFF_W-1:0]  loff_reg, loff_next;
    logic                        lmode_reg, lmode_next;
    logic [AW-1:0]               malign_reg, malign_next;

    rsv_t                        rv;
    fin_t                        fv;
    dec_t                        dv;
    logic                        is_x;
    logic                        do_start;
    logic                        digit_ok;
    logic [1:0]                  cnt;
    pfop_pkg::res_t              slot [2];

    assign digit_ok = (fmt_char >= CH_ZERO) && (fmt_char <= CH_NINE) &&
                      !(seen_reg && num_reg > pfop_pkg::NUM_LIMIT);

    always_comb
    begin
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        num_next    = num_reg;
        seen_next   = seen_reg;
        apend_next  = apend_reg;
        loff_next   = loff_reg;
        lmode_next  = lmode_reg;
        malign_next = malign_reg;
        rv          = '0;
        fv          = '0;
        dv          = '0;
        is_x        = 1'b0;
        do_start    = 1'b0;
        cnt         = 2'd0;
        slot[0]     = '0;
        slot[1]     = '0;

        if (phase_reg == PH_NUM)
        begin
            if (digit_ok)
            begin
                // times ten as two shifts, plus the digit
                num_next  = {num_reg[CW-4:0], 3'b000} + {num_reg[CW-2:0], 1'b0}
                            + CW'(fmt_char[3:0]);
                seen_next = 1'b1;
            end
            else
            begin
                rv   = resolve_opt(pend_reg, num_reg, seen_reg, cfg);
                is_x = apend_reg;
                if (rv.set_ma)
                    malign_next = rv.ma;
                apend_next = 1'b0;
                num_next   = '0;
                seen_next  = 1'b0;
                fv = finish_opt(rv.kind, rv.size, rv.err, is_x, malign_next, loff_next);
                slot[cnt[0]] = to_res(fv, lmode_next);
                cnt          = cnt + 2'd1;
                phase_next   = fv.skip ? PH_SKIP : PH_IDLE;
                do_start     = !fv.skip;
            end
        end
        else if (phase_reg != PH_SKIP)
            do_start = 1'b1;

        if (do_start)
        begin
            is_x = (phase_next == PH_XWAIT);
            if (!is_x)
                loff_next = offset;
            if (!is_x && fmt_char == CH_UP_X)
                phase_next = PH_XWAIT;
            else if (takes_numeral(fmt_char))
            begin
                pend_next  = fmt_char;
                num_next   = '0;
                seen_next  = 1'b0;
                apend_next = is_x;
                phase_next = PH_NUM;
            end
            else
            begin
                dv         = decode_plain(fmt_char, lmode_next, cfg);
                lmode_next = dv.little;
                fv = finish_opt(dv.kind, dv.size, dv.err, is_x, malign_next, loff_next);
                if (cnt != 2'd2)
                begin
                    slot[cnt[0]] = to_res(fv, lmode_next);
                    cnt          = cnt + 2'd1;
                end
                phase_next = fv.skip ? PH_SKIP : PH_IDLE;
            end
        end

        if (format_end)
        begin
            if (phase_next == PH_NUM)
            begin
                rv   = resolve_opt(pend_next, num_next, seen_next, cfg);
                is_x = apend_next;
                if (rv.set_ma)
                    malign_next = rv.ma;
                fv = finish_opt(rv.kind, rv.size, rv.err, is_x, malign_next, loff_next);
                if (cnt != 2'd2)
                begin
                    slot[cnt[0]] = to_res(fv, lmode_next);
                    cnt          = cnt + 2'd1;
                end
            end
            else if (phase_next == PH_XWAIT)
            begin
                // X as the final character has no target
                fv      = '0;
                fv.kind = pfop_pkg::K_NOP;
                fv.err  = pfop_pkg::E_X_TARGET;
                fv.skip = 1'b1;
                if (cnt != 2'd2)
                begin
                    slot[cnt[0]] = to_res(fv, lmode_next);
                    cnt          = cnt + 2'd1;
                end
            end
            if (cnt == 2'd0)
            begin
                fv      = '0;
                fv.kind = pfop_pkg::K_NOP;
                fv.err  = pfop_pkg::E_NONE;
                slot[0] = to_res(fv, lmode_next);
                cnt     = 2'd1;
            end
            if (cnt == 2'd2)
                slot[1].done_res = 1'b1;
            else
                slot[0].done_res = 1'b1;
            // back to start-of-format values
            phase_next  = PH_IDLE;
            pend_next   = '0;
            num_next    = '0;
            seen_next   = 1'b0;
            apend_next  = 1'b0;
            lmode_next  = cfg.native_little;
            malign_next = AW'(1);
        end

        if (cnt == 2'd2)
            slot[1].run_end = 1'b1;
        else if (cnt == 2'd1)
            slot[0].run_end = 1'b1;
    end

    assign res0    = slot[0];
    assign res1    = slot[1];
    assign res_num = cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pend_reg   <= '0;
            num_reg    <= '0;
            seen_reg   <= 1'b0;
            apend_reg  <= 1'b0;
            loff_reg   <= '0;
            lmode_reg  <= 1'b1;
            malign_reg <= AW'(1);
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            num_reg    <= num_next;
            seen_reg   <= seen_next;
            apend_reg  <= apend_next;
            loff_reg   <= loff_next;
            lmode_reg  <= lmode_next;
            malign_reg <= malign_next;
        end
    end

endmodule

// ----- design/pack_format_option_parser.sv -----
// ----------------------------------------------------------------------------
// pack_format_option_parser
// A word's results are written to the result queue when it is accepted.
// Throughput: one format character per cycle; results leave one per cycle
// through a four-entry result queue, so a character yielding two results
// takes two of its entries. Input stalls while fewer than two slots
// are free. Reset clears the parser state, the queue and loads register
// defaults asynchronously; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pack_format_option_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [pfop_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [pfop_pkg::CFG_W-1:0]       cfg_wdata,
    pfop_fmt_if.sink                         fmt,
    pfop_res_if.source                       res
);

    localparam int RES_DEPTH = 4;
    localparam int PTR_W     = 2;
    localparam int FILL_W    = 3;

    pfop_pkg::cfg_t   cfg_reg;
    pfop_pkg::res_t   res0, res1, head;
    logic [1:0]       res_num;
    logic [1:0]       push_num;
    logic             accept;
    logic             pop;

    pfop_pkg::res_t   fifo_reg [RES_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [FILL_W-1:0] fill_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.native_little    <= 1'b1;
            cfg_reg.native_max_align <= 5'd8;
            cfg_reg.int_bytes        <= 5'd4;
            cfg_reg.long_bytes       <= 5'd8;
            cfg_reg.integer_bytes    <= 5'd8;
            cfg_reg.sizet_bytes      <= 5'd8;
            cfg_reg.number_bytes     <= 5'd8;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx)
                pfop_pkg::CFG_NATIVE_LITTLE:    cfg_reg.native_little    <= cfg_wdata[0];
                pfop_pkg::CFG_NATIVE_MAX_ALIGN: cfg_reg.native_max_align <= cfg_wdata;
                pfop_pkg::CFG_INT_BYTES:        cfg_reg.int_bytes        <= cfg_wdata;
                pfop_pkg::CFG_LONG_BYTES:       cfg_reg.long_bytes       <= cfg_wdata;
                pfop_pkg::CFG_INTEGER_BYTES:    cfg_reg.integer_bytes    <= cfg_wdata;
                pfop_pkg::CFG_SIZET_BYTES:      cfg_reg.sizet_bytes      <= cfg_wdata;
                pfop_pkg::CFG_NUMBER_BYTES:     cfg_reg.number_bytes     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // room for the worst case of two results per word
    assign fmt.ready = (fill_reg <= FILL_W'(RES_DEPTH - 2));
    assign accept    = fmt.valid && fmt.ready;
    assign res.valid = (fill_reg != '0);
    assign pop       = res.valid && res.ready;
    assign push_num  = accept ? res_num : 2'd0;

    pfop_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .fmt_char   (fmt.fmt_char),
        .offset     (fmt.offset),
        .format_end (fmt.format_end),
        .cfg        (cfg_reg),
        .res0       (res0),
        .res1       (res1),
        .res_num    (res_num)
    );

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            fifo_reg[wptr_reg] <= res0;
        if (push_num == 2'd2)
            fifo_reg[wptr_reg + PTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + PTR_W'(push_num);
            rptr_reg <= rptr_reg + PTR_W'(pop);
            fill_reg <= fill_reg + FILL_W'(push_num) - FILL_W'(pop);
        end
    end

    assign head         = fifo_reg[rptr_reg];
    assign res.kind     = head.kind;
    assign res.size     = head.size;
    assign res.pad      = head.pad;
    assign res.little   = head.little;
    assign res.error    = head.error;
    assign res.run_end  = head.run_end;
    assign res.done_res = head.done_res;

    `ASSERT_CLK(a_end_gives_word, (fmt.valid && fmt.ready && fmt.format_end) |=> res.valid, "format end produced no result")
    `ASSERT_CLK(a_done_is_last, (res.valid && res.done_res) |-> res.run_end, "closing result is not the last of its word")
    `ASSERT_NEVER(a_fill_bound, fill_reg > FILL_W'(RES_DEPTH), "result queue overflow")

endmodule
